@@ hw/rtl/rne_pkg.sv @@
`timescale 1ns / 1ps
package rne_pkg;

	// network shape
	localparam int N_INPUTS  = 4;
	localparam int N_OUTPUTS = 4;
	localparam int N_HIDDEN  = 8;
	localparam int NN        = 2 + N_INPUTS + N_OUTPUTS + N_HIDDEN;
	localparam int FIRST_IN  = 2;
	localparam int FIRST_OUT = 2 + N_INPUTS;
	localparam int SYN_DEPTH = NN * NN;

	// field widths
	localparam int NODE_W = 5;
	localparam int DATA_W = 32;
	localparam int LIM_W  = 31;
	localparam int CYC_W  = 10;
	localparam int OIDX_W = 2;
	localparam int FRAC_W = 16;
	localparam int ADDR_W = $clog2(SYN_DEPTH);
	localparam int POS_W  = $clog2(N_INPUTS + 1);

	localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;

	// operation codes of an input item
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_INPUT = 1'b1;

	typedef enum logic {
		CMD_WRITE,
		CMD_INPUT
	} cmd_kind_t;

	// one queued command from the front to the back
	typedef struct packed {
		cmd_kind_t               kind;
		logic [ADDR_W-1:0]       addr;
		logic signed [DATA_W-1:0] weight;
		logic                    connected;
		logic signed [DATA_W-1:0] value;
		logic                    last;
	} cmd_t;

	// configuration registers
	typedef struct packed {
		logic [CYC_W-1:0]         max_cycles;
		logic signed [DATA_W-1:0] initial_node_value;
		logic [LIM_W-1:0]         value_limit;
		logic [LIM_W-1:0]         output_limit;
	} cfg_t;

	// back status seen by the front
	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

@@ hw/rtl/rne_item_if.sv @@
`timescale 1ns / 1ps
interface rne_item_if import rne_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic [NODE_W-1:0]        dest_node;
	logic [NODE_W-1:0]        source_node;
	logic signed [DATA_W-1:0] weight;
	logic                     connected;
	logic signed [DATA_W-1:0] input_value;
	logic                     input_last;

	modport source (
		output valid, operation, dest_node, source_node, weight, connected,
		input_value, input_last,
		input  ready
	);
	modport sink (
		input  valid, operation, dest_node, source_node, weight, connected,
		input_value, input_last,
		output ready
	);
endinterface

@@ hw/rtl/rne_result_if.sv @@
`timescale 1ns / 1ps
interface rne_result_if import rne_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OIDX_W-1:0]        output_index;
	logic signed [DATA_W-1:0] output_value;
	logic                     triggered_flag;
	logic [CYC_W-1:0]         cycles_used;
	logic                     last_output;

	modport source (
		output valid, output_index, output_value, triggered_flag, cycles_used,
		last_output,
		input  ready
	);
	modport sink (
		input  valid, output_index, output_value, triggered_flag, cycles_used,
		last_output,
		output ready
	);
endinterface

@@ hw/rtl/rne_queue.sv @@
`timescale 1ns / 1ps
module rne_queue import rne_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic nonempty
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue pushed while full");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a push");
endmodule

@@ hw/rtl/rne_front.sv @@
`timescale 1ns / 1ps
module rne_front import rne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rne_item_if.sink   items,
	input  back_stat_t stat,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);
	logic dest_ok;
	logic src_ok;
	logic accept;

	// synapse validity: dest not bias or input, source not trigger or output
	always_comb begin
		dest_ok = (int'(items.dest_node) < NN) && (items.dest_node != NODE_W'(1))
			&& !((int'(items.dest_node) >= FIRST_IN) && (int'(items.dest_node) < FIRST_OUT));
		src_ok  = (int'(items.source_node) < NN) && (items.source_node != '0)
			&& !((int'(items.source_node) >= FIRST_OUT)
			&& (int'(items.source_node) < FIRST_OUT + N_OUTPUTS));
	end

	assign items.ready = !q_full && !stat.clearing;
	assign accept      = items.valid && items.ready;

	// classify the transfer; invalid synapse writes are dropped here
	always_comb begin
		push_cmd.kind      = (items.operation == OP_INPUT) ? CMD_INPUT : CMD_WRITE;
		push_cmd.addr      = ADDR_W'(items.dest_node) * ADDR_W'(NN) + ADDR_W'(items.source_node);
		push_cmd.weight    = items.weight;
		push_cmd.connected = items.connected;
		push_cmd.value     = items.input_value;
		push_cmd.last      = items.input_last;
		push = accept && ((items.operation == OP_INPUT) || (dest_ok && src_ok));
	end

	a_drop_only_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !push) |-> (items.operation == OP_WRITE))
		else $error("input transfer dropped");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !push) else $error("push during map clear");
	a_bias_dest_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && items.operation == OP_WRITE && items.dest_node == NODE_W'(1)) |-> !push)
		else $error("write to bias kept");
endmodule

@@ hw/rtl/rne_back.sv @@
`timescale 1ns / 1ps
module rne_back import rne_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  cmd_t         head,
	input  logic         nonempty,
	output logic         pop,
	output back_stat_t   stat,
	rne_result_if.source results
);
	localparam int ACC_W  = 2 * DATA_W - FRAC_W + $clog2(NN);
	localparam int PROD_W = 2 * DATA_W;
	localparam int K_W    = (N_OUTPUTS > 1) ? $clog2(N_OUTPUTS) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_RUN,
		S_DRAIN,
		S_COMMIT,
		S_EMIT
	} state_t;

	// symmetric saturation of a wide sum
	function automatic logic signed [DATA_W-1:0] sat_wide(
		input logic signed [ACC_W-1:0] v,
		input logic [LIM_W-1:0] lim
	);
		logic signed [ACC_W-1:0] pos_w;
		logic signed [ACC_W-1:0] neg_w;
		pos_w = $signed({{(ACC_W - LIM_W){1'b0}}, lim});
		neg_w = -pos_w;
		if (v > pos_w) begin
			sat_wide = pos_w[DATA_W-1:0];
		end else if (v < neg_w) begin
			sat_wide = neg_w[DATA_W-1:0];
		end else begin
			sat_wide = v[DATA_W-1:0];
		end
	endfunction

	state_t                   state_q;
	logic [ADDR_W-1:0]        clr_q;
	logic [ADDR_W-1:0]        a_q;
	logic [NODE_W-1:0]        d_q;
	logic [NODE_W-1:0]        s_q;
	logic [CYC_W-1:0]         cycles_q;
	logic [POS_W-1:0]         pos_q;
	logic [K_W-1:0]           k_q;
	logic                     ov_q;
	logic [OIDX_W-1:0]        oidx_q;
	logic signed [DATA_W-1:0] oval_q;
	logic                     otrig_q;
	logic [CYC_W-1:0]         ocyc_q;
	logic                     olast_q;

	logic signed [DATA_W-1:0] cur_q [NN];
	logic signed [DATA_W-1:0] nxt_q [NN];
	logic [DATA_W:0]          syn_mem [SYN_DEPTH];

	logic                     v_s1, first_s1, last_s1;
	logic [DATA_W:0]          rdata_s1;
	logic signed [DATA_W-1:0] nv_s1;
	logic                     v_s2, first_s2, last_s2, pres_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sum_v_s3;
	logic signed [ACC_W-1:0]  sum_s3;
	logic [NODE_W-1:0]        d_s1, d_s2, d_s3;

	logic                     take_input;
	logic                     start_eval;
	logic [POS_W-1:0]         pos_eff;
	logic                     trig;
	logic [NODE_W-1:0]        rd_node;
	logic                     emit_load;
	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_waddr;
	logic [DATA_W:0]          mem_wdata;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_next;

	// command decode
	assign pop        = (state_q == S_IDLE) && nonempty;
	assign take_input = pop && (head.kind == CMD_INPUT);
	assign start_eval = take_input && head.last;
	assign pos_eff    = (int'(pos_q) < N_INPUTS) ? pos_q + 1'b1 : pos_q;
	assign trig       = (cur_q[0] >= ONE_Q16);
	assign rd_node    = (state_q == S_EMIT) ? NODE_W'(FIRST_OUT) + NODE_W'(k_q) : s_q;
	assign emit_load  = (state_q == S_EMIT) && (!ov_q || results.ready);
	assign stat.clearing = (state_q == S_CLEAR);

	// synapse map write: clearing pass or a synapse command
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || (pop && head.kind == CMD_WRITE);
		mem_waddr = (state_q == S_CLEAR) ? clr_q : head.addr;
		if ((state_q == S_CLEAR) || !head.connected) begin
			mem_wdata = '0;
		end else begin
			mem_wdata = {1'b1, sat_wide(ACC_W'(head.weight), cfg.value_limit)};
		end
	end

	// synapse memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			syn_mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= syn_mem[a_q];
	end

	// multiply-accumulate datapath
	always_comb begin
		term     = pres_s2 ? ACC_W'($signed(prod_s2[PROD_W-1:FRAC_W])) : '0;
		acc_next = (first_s2 ? '0 : acc_q) + term;
	end

	always_ff @(posedge clk) begin
		nv_s1    <= cur_q[rd_node];
		first_s1 <= (s_q == '0);
		last_s1  <= (s_q == NODE_W'(NN - 1));
		d_s1     <= d_q;
		prod_s2  <= $signed(rdata_s1[DATA_W-1:0]) * nv_s1;
		pres_s2  <= rdata_s1[DATA_W];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		d_s2     <= d_s1;
		if (v_s2) begin
			acc_q  <= acc_next;
			sum_s3 <= acc_next;
			d_s3   <= d_s2;
		end
		if (sum_v_s3) begin
			nxt_q[d_s3] <= sat_wide(sum_s3, cfg.value_limit);
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			sum_v_s3 <= 1'b0;
		end else begin
			v_s1     <= (state_q == S_RUN);
			v_s2     <= v_s1;
			sum_v_s3 <= v_s2 && last_s2;
		end
	end

	// node values: input fill, evaluation start, commit of one update
	always_ff @(posedge clk) begin
		if (take_input && (int'(pos_q) < N_INPUTS)) begin
			cur_q[NODE_W'(FIRST_IN + int'(pos_q))] <= head.value;
		end
		if (start_eval) begin
			cur_q[0] <= '0;
			cur_q[1] <= ONE_Q16;
			for (int j = 0; j < N_INPUTS; j++) begin
				if (j >= int'(pos_eff)) begin
					cur_q[FIRST_IN + j] <= cfg.initial_node_value;
				end
			end
			for (int i = FIRST_OUT; i < NN; i++) begin
				cur_q[i] <= cfg.initial_node_value;
			end
		end
		if (state_q == S_COMMIT) begin
			cur_q[0] <= nxt_q[0];
			for (int i = FIRST_OUT; i < NN; i++) begin
				cur_q[i] <= nxt_q[i];
			end
		end
	end

	// control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			a_q      <= '0;
			d_q      <= '0;
			s_q      <= '0;
			cycles_q <= '0;
			pos_q    <= '0;
			k_q      <= '0;
			ov_q     <= 1'b0;
			oidx_q   <= '0;
			oval_q   <= '0;
			otrig_q  <= 1'b0;
			ocyc_q   <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (ov_q && results.ready && !emit_load) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(SYN_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start_eval) begin
						pos_q    <= '0;
						cycles_q <= '0;
						state_q  <= S_CHECK;
					end else if (take_input) begin
						pos_q <= pos_eff;
					end
				end
				S_CHECK: begin
					if ((cycles_q < cfg.max_cycles) && !trig) begin
						a_q     <= '0;
						d_q     <= '0;
						s_q     <= '0;
						state_q <= S_RUN;
					end else begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_RUN: begin
					a_q <= a_q + 1'b1;
					if (s_q == NODE_W'(NN - 1)) begin
						s_q <= '0;
						d_q <= d_q + 1'b1;
					end else begin
						s_q <= s_q + 1'b1;
					end
					if (a_q == ADDR_W'(SYN_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2 && !sum_v_s3) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					cycles_q <= cycles_q + 1'b1;
					state_q  <= S_CHECK;
				end
				S_EMIT: begin
					if (emit_load) begin
						ov_q    <= 1'b1;
						oidx_q  <= OIDX_W'(k_q);
						oval_q  <= sat_wide(ACC_W'(cur_q[rd_node]), cfg.output_limit);
						otrig_q <= trig;
						ocyc_q  <= cycles_q;
						olast_q <= (int'(k_q) == N_OUTPUTS - 1);
						k_q     <= k_q + 1'b1;
						if (int'(k_q) == N_OUTPUTS - 1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid          = ov_q;
	assign results.output_index   = oidx_q;
	assign results.output_value   = oval_q;
	assign results.triggered_flag = otrig_q;
	assign results.cycles_used    = ocyc_q;
	assign results.last_output    = olast_q;

	a_row_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		sum_v_s3 |-> (state_q == S_RUN || state_q == S_DRAIN))
		else $error("row sum outside an update");
	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |-> (!v_s1 && !v_s2 && !sum_v_s3))
		else $error("commit before pipeline drained");
	a_cycle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (cycles_q <= cfg.max_cycles))
		else $error("update count beyond limit");
endmodule

@@ hw/rtl/recurrent_net_evaluator_unit.sv @@
`timescale 1ns / 1ps
// synapse writes and plain inputs pass through a two-entry queue and are taken by the back end when idle
// an evaluating input runs U updates, U = update count, each a single multiply-accumulate pass over all
// NN*NN synapse slots plus drain, commit and check; then one result per output node per cycle while the
// result receiver is ready
// reset: asynchronous, then a clearing pass over all NN*NN (324) synapse slots with no item accepted
module recurrent_net_evaluator_unit import rne_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	rne_item_if.sink           items,
	rne_result_if.source       results,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [DATA_W-1:0]  cfg_data
);
	localparam logic [1:0] REG_MAX_CYCLES   = 2'd0;
	localparam logic [1:0] REG_INITIAL_NODE = 2'd1;
	localparam logic [1:0] REG_VALUE_LIMIT  = 2'd2;
	localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd3;

	cfg_t       cfg_q;
	back_stat_t stat;
	logic       q_full;
	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	cmd_t       head;
	logic       nonempty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_cycles         <= CYC_W'(16);
			cfg_q.initial_node_value <= '0;
			cfg_q.value_limit        <= {LIM_W{1'b1}};
			cfg_q.output_limit       <= LIM_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_CYCLES:   cfg_q.max_cycles         <= cfg_data[CYC_W-1:0];
				REG_INITIAL_NODE: cfg_q.initial_node_value <= cfg_data;
				REG_VALUE_LIMIT:  cfg_q.value_limit        <= cfg_data[LIM_W-1:0];
				REG_OUTPUT_LIMIT: cfg_q.output_limit       <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rne_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.stat     (stat),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	rne_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty)
	);

	rne_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.stat     (stat),
		.results  (results)
	);
endmodule

@@ verif/recurrent_net_evaluator_unit_tb.sv @@
`timescale 1ns / 1ps
module recurrent_net_evaluator_unit_tb;
	import rne_pkg::*;

	// register indexes of the configuration port
	localparam logic [1:0] REG_MAX_CYCLES = 2'd0;
	localparam logic [1:0] REG_INIT_VALUE = 2'd1;
	localparam logic [1:0] REG_VALUE_LIM  = 2'd2;
	localparam logic [1:0] REG_OUT_LIM    = 2'd3;

	localparam int  RANDOM_ITEMS = 85;
	localparam int  STALL_LIMIT  = 2000000;
	localparam int  DRAIN_CYCLES = 20;
	localparam longint Q_ONE     = 65536;

	typedef struct {
		logic                     op;
		logic [NODE_W-1:0]        dest;
		logic [NODE_W-1:0]        src;
		logic signed [DATA_W-1:0] wgt;
		logic                     conn;
		logic signed [DATA_W-1:0] ival;
		logic                     last;
	} net_item_t;

	typedef struct {
		logic [OIDX_W-1:0]        idx;
		logic signed [DATA_W-1:0] value;
		logic                     trig;
		logic [CYC_W-1:0]         cycles;
		logic                     last;
	} net_output_t;

	typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

	typedef struct {
		row_kind_t                kind;
		net_item_t                it;
		logic [1:0]               reg_idx;
		logic [DATA_W-1:0]        reg_val;
		bit                       known;
		logic signed [DATA_W-1:0] k_value;
		logic                     k_trig;
		logic [CYC_W-1:0]         k_cycles;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	rne_item_if   items ();
	rne_result_if results ();

	recurrent_net_evaluator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items.sink),
		.results   (results.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// network shadow state and configuration
	longint      node_val [NN];
	longint      syn_wgt [SYN_DEPTH];
	bit          syn_on [SYN_DEPTH];
	int          fill_pos;
	longint      cfg_max_cycles;
	longint      cfg_init_value;
	longint      cfg_value_lim;
	longint      cfg_out_lim;

	net_output_t pending_outputs[$];
	stim_row_t   stim_rows[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          quiet_send = 1'b0;
	bit          quiet_recv = 1'b0;

	function automatic longint sat_sym(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic bit is_in_node(int n);
		return n >= FIRST_IN && n < FIRST_OUT;
	endfunction

	function automatic bit is_out_node(int n);
		return n >= FIRST_OUT && n < FIRST_OUT + N_OUTPUTS;
	endfunction

	function automatic void clear_network();
		cfg_max_cycles = 16;
		cfg_init_value = 0;
		cfg_value_lim  = 64'h7FFFFFFF;
		cfg_out_lim    = Q_ONE;
		foreach (node_val[i]) node_val[i] = 0;
		node_val[1] = Q_ONE;
		foreach (syn_wgt[i]) begin
			syn_wgt[i] = 0;
			syn_on[i]  = 1'b0;
		end
		fill_pos = 0;
	endfunction

	// apply one accepted item to the shadow network, queue any outputs it yields
	function automatic void net_apply_item(net_item_t it, bit known, logic signed [DATA_W-1:0] kv,
			logic kt, logic [CYC_W-1:0] kc);
		int          d;
		int          s;
		int          a;
		longint      acc;
		longint      nxt [NN];
		longint      cyc;
		bit          trig;
		net_output_t o;
		d = it.dest;
		s = it.src;
		if (it.op == OP_WRITE) begin
			if (d >= NN || s >= NN) return;
			if (d == 1 || is_in_node(d)) return;
			if (s == 0 || is_out_node(s)) return;
			a = d * NN + s;
			syn_on[a]  = it.conn;
			syn_wgt[a] = it.conn ? sat_sym(longint'(it.wgt), cfg_value_lim) : 0;
			return;
		end
		if (fill_pos < N_INPUTS) begin
			node_val[FIRST_IN + fill_pos] = longint'(it.ival);
			fill_pos++;
		end
		if (!it.last) return;
		for (int i = 0; i < NN; i++) begin
			if (is_in_node(i) && i - FIRST_IN < fill_pos) continue;
			node_val[i] = cfg_init_value;
		end
		node_val[0] = 0;
		node_val[1] = Q_ONE;
		fill_pos = 0;
		cyc = 0;
		// synchronous sweeps until the trigger fires or the bound is hit
		while (cyc < cfg_max_cycles && node_val[0] < Q_ONE) begin
			for (int dn = 0; dn < NN; dn++) begin
				acc = 0;
				for (int sn = 0; sn < NN; sn++)
					if (syn_on[dn * NN + sn]) acc += (node_val[sn] * syn_wgt[dn * NN + sn]) >>> 16;
				nxt[dn] = sat_sym(acc, cfg_value_lim);
			end
			for (int dn = 0; dn < NN; dn++)
				if (dn != 1 && !is_in_node(dn)) node_val[dn] = nxt[dn];
			cyc++;
		end
		trig = node_val[0] >= Q_ONE;
		for (int k = 0; k < N_OUTPUTS; k++) begin
			o.idx    = OIDX_W'(k);
			o.value  = known ? kv : DATA_W'(sat_sym(node_val[FIRST_OUT + k], cfg_out_lim));
			o.trig   = known ? kt : trig;
			o.cycles = known ? kc : cyc[CYC_W-1:0];
			o.last   = (k == N_OUTPUTS - 1);
			pending_outputs = {pending_outputs, o};
		end
	endfunction

	// row builders for the directed table
	function automatic void add_write(int d, int s, logic [31:0] w, bit c);
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: '0};
		r.it = '{op: OP_WRITE, dest: NODE_W'(d), src: NODE_W'(s), wgt: w, conn: c, ival: '0,
			last: 1'b0};
		stim_rows = {stim_rows, r};
	endfunction

	function automatic void add_input(logic [31:0] v, bit l);
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: '0};
		r.it = '{op: OP_INPUT, dest: '0, src: '0, wgt: '0, conn: 1'b0, ival: v, last: l};
		stim_rows = {stim_rows, r};
	endfunction

	function automatic void add_known(logic [31:0] v, bit t, int c);
		stim_rows[$].known    = 1'b1;
		stim_rows[$].k_value  = v;
		stim_rows[$].k_trig   = t;
		stim_rows[$].k_cycles = CYC_W'(c);
	endfunction

	function automatic void add_cfg(logic [1:0] i, logic [31:0] v);
		stim_row_t r;
		r = '{kind: ROW_CFG, default: '0};
		r.reg_idx = i;
		r.reg_val = v;
		stim_rows = {stim_rows, r};
	endfunction

	// drive one item, wait for its transfer, then update the shadow network
	task automatic send_item(net_item_t it, bit known = 1'b0, logic [31:0] kv = '0,
			logic kt = 1'b0, logic [CYC_W-1:0] kc = '0);
		int gap;
		if ($urandom_range(0, 15) == 0) quiet_send = ~quiet_send;
		gap = quiet_send ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid       <= 1'b1;
		items.operation   <= it.op;
		items.dest_node   <= it.dest;
		items.source_node <= it.src;
		items.weight      <= it.wgt;
		items.connected   <= it.conn;
		items.input_value <= it.ival;
		items.input_last  <= it.last;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		net_apply_item(it, known, kv, kt, kc);
	endtask

	// hold the sender until every expected output has come and the back end settles
	task automatic drain_outputs();
		items.valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] i, logic [31:0] v);
		drain_outputs();
		cfg_we    <= 1'b1;
		cfg_index <= i;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (i)
			REG_MAX_CYCLES: cfg_max_cycles = v[CYC_W-1:0];
			REG_INIT_VALUE: cfg_init_value = longint'($signed(v));
			REG_VALUE_LIM:  cfg_value_lim  = v[LIM_W-1:0];
			REG_OUT_LIM:    cfg_out_lim    = v[LIM_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_weight();
		if ($urandom_range(0, 5) == 0) return $urandom;
		return $urandom_range(0, 32'h40000) - 32'h20000;
	endfunction

	function automatic logic [31:0] rand_value();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return $urandom_range(0, 32'h60000) - 32'h30000;
	endfunction

	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 3))
			0: return 32'h7FFFFFFF;
			1: return $urandom_range(0, 32'hFFFF);
			2: return $urandom_range(32'h10000, 32'h80000);
			default: return $urandom & 32'h7FFFFFFF;
		endcase
	endfunction

	// result side: random stalls, compare each transfer to the oldest expectation
	initial begin
		int stall;
		results.ready <= 1'b0;
		forever begin
			if ($urandom_range(0, 15) == 0) quiet_recv = ~quiet_recv;
			stall = quiet_recv ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			@(posedge clk);
			while (!results.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		net_output_t e;
		if (results.valid && results.ready) begin
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: index %0d value %0h", results.output_index,
						results.output_value);
			end else begin
				e = pending_outputs.pop_front();
				if (results.output_index !== e.idx || results.output_value !== e.value ||
						results.triggered_flag !== e.trig || results.cycles_used !== e.cycles ||
						results.last_output !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"output mismatch: exp idx %0d val %0h trig %0b cyc %0d last %0b",
							" / got idx %0d val %0h trig %0b cyc %0d last %0b"},
							e.idx, e.value, e.trig, e.cycles, e.last,
							results.output_index, results.output_value, results.triggered_flag,
							results.cycles_used, results.last_output);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("recurrent_net_evaluator_unit_tb NOT OK");
			$finish;
		end
	end

	// main sequence
	initial begin
		int        sent;
		int        n_wr;
		int        n_in;
		net_item_t it;
		items.valid       <= 1'b0;
		items.operation   <= OP_WRITE;
		items.dest_node   <= '0;
		items.source_node <= '0;
		items.weight      <= '0;
		items.connected   <= 1'b0;
		items.input_value <= '0;
		items.input_last  <= 1'b0;
		clear_network();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty network, legal and illegal synapses, input handling, limits
		add_input(32'h0, 1'b1);
		add_known(32'h0, 1'b0, 16);
		add_write(0, 1, 32'h7FFFFFFF, 1'b1);
		add_write(6, 1, 32'h80000000, 1'b1);
		add_write(7, 2, 32'h00018000, 1'b1);
		add_write(10, 3, 32'hFFFF0000, 1'b1);
		add_write(8, 10, 32'h00020000, 1'b1);
		add_write(1, 2, 32'h00010000, 1'b1);
		add_write(3, 10, 32'h00010000, 1'b1);
		add_write(10, 0, 32'h00010000, 1'b1);
		add_write(10, 6, 32'h00010000, 1'b1);
		add_write(31, 31, 32'h00010000, 1'b1);
		add_write(18, 17, 32'h00010000, 1'b1);
		add_input(32'h7FFFFFFF, 1'b0);
		add_input(32'h80000000, 1'b0);
		add_input(32'h00012345, 1'b0);
		add_input(32'hFFFFFFFB, 1'b0);
		add_input(32'h00000063, 1'b0);
		add_input(32'h00000007, 1'b1);
		add_write(6, 1, 32'h0, 1'b0);
		add_input(32'h00010000, 1'b1);
		// trigger cannot reach 1.0: full sweep count
		add_cfg(REG_VALUE_LIM, 32'h00008000);
		add_cfg(REG_MAX_CYCLES, 32'd1023);
		add_input(32'h00030000, 1'b1);
		// no sweeps: outputs report the start value
		add_cfg(REG_VALUE_LIM, 32'h7FFFFFFF);
		add_cfg(REG_MAX_CYCLES, 32'd0);
		add_cfg(REG_INIT_VALUE, 32'h80000000);
		add_cfg(REG_OUT_LIM, 32'h7FFFFFFF);
		add_input(32'h0, 1'b1);
		add_known(32'h80000001, 1'b0, 0);
		// trigger wired from bias fires on the first sweep
		add_cfg(REG_MAX_CYCLES, 32'd1023);
		add_cfg(REG_OUT_LIM, 32'h0);
		add_input(32'h00010000, 1'b1);
		add_cfg(REG_MAX_CYCLES, 32'd16);
		add_cfg(REG_INIT_VALUE, 32'h0);
		add_cfg(REG_OUT_LIM, 32'h00010000);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG)
				write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
			else
				send_item(stim_rows[i].it, stim_rows[i].known, stim_rows[i].k_value,
					stim_rows[i].k_trig, stim_rows[i].k_cycles);
		end

		// random: episodes of synapse edits followed by an input burst ending in an evaluation
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_MAX_CYCLES, ($urandom_range(0, 99) < 85) ?
					$urandom_range(0, 6) : 16);
				if ($urandom_range(0, 1)) write_reg(REG_VALUE_LIM, rand_limit());
				if ($urandom_range(0, 1)) write_reg(REG_OUT_LIM, rand_limit());
				if ($urandom_range(0, 1)) write_reg(REG_INIT_VALUE, rand_value());
			end
			n_wr = $urandom_range(0, 6);
			n_in = $urandom_range(1, 6);
			for (int w = 0; w < n_wr; w++) begin
				it.op   = OP_WRITE;
				it.ival = $urandom;
				it.last = $urandom_range(0, 1);
				it.wgt  = rand_weight();
				it.conn = $urandom_range(0, 5) != 0;
				if ($urandom_range(0, 4) == 0) begin
					it.dest = $urandom;
					it.src  = $urandom;
				end else begin
					case ($urandom_range(0, 2))
						0: it.dest = 0;
						1: it.dest = $urandom_range(FIRST_OUT, FIRST_OUT + N_OUTPUTS - 1);
						default: it.dest = $urandom_range(FIRST_OUT + N_OUTPUTS, NN - 1);
					endcase
					it.src = $urandom_range(0, 1) ? $urandom_range(1, FIRST_OUT - 1) :
						$urandom_range(FIRST_OUT + N_OUTPUTS, NN - 1);
				end
				send_item(it);
				sent++;
			end
			for (int j = 0; j < n_in; j++) begin
				it.op   = OP_INPUT;
				it.dest = $urandom;
				it.src  = $urandom;
				it.wgt  = $urandom;
				it.conn = $urandom_range(0, 1);
				it.ival = rand_value();
				it.last = (j == n_in - 1);
				send_item(it);
				sent++;
			end
			// now and then the sender holds off until every output is back
			if ($urandom_range(0, 5) == 0) drain_outputs();
		end

		items.valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_outputs.size() == 0) begin
			$display("recurrent_net_evaluator_unit_tb OK");
		end else begin
			$display("recurrent_net_evaluator_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
